[hw/rtl/ptec_pkg.sv]
// Package for the priority timed effect controller.
// Effect, operation, power state and register index codes shared by the RTL.
// No dependencies.
`default_nettype none

package ptec_pkg;

  localparam int unsigned TimeW = 32;

  // effect codes, value equals priority
  localparam logic [2:0] FX_NONE     = 3'd0;
  localparam logic [2:0] FX_STARTUP  = 3'd1;
  localparam logic [2:0] FX_RESET    = 3'd2;
  localparam logic [2:0] FX_SHUTDOWN = 3'd3;
  localparam logic [2:0] FX_FORCED   = 3'd4;

  // operation codes
  localparam logic [2:0] OP_REQUEST   = 3'd0;
  localparam logic [2:0] OP_RESTART   = 3'd1;
  localparam logic [2:0] OP_CANCEL    = 3'd2;
  localparam logic [2:0] OP_RECONCILE = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;
  localparam logic [2:0] OP_CONSUME   = 3'd5;

  // machine power state codes
  localparam logic [1:0] PS_OTHER    = 2'd0;
  localparam logic [1:0] PS_STARTING = 2'd1;
  localparam logic [1:0] PS_RUNNING  = 2'd2;
  localparam logic [1:0] PS_SHUTTING = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_STARTUP_DUR  = 2'd0;
  localparam logic [1:0] REG_SHUTDOWN_DUR = 2'd1;
  localparam logic [1:0] REG_RESET_DUR    = 2'd2;

endpackage : ptec_pkg

`default_nettype wire

[hw/rtl/ptec_if.sv]
// Valid/ready channel interfaces for the effect controller: event in, result out.
// Depends on ptec_pkg.
`default_nettype none

interface ptec_in_if;
  import ptec_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       func;
  logic [2:0]       effect;
  logic [1:0]       pc_state;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, output func, output effect, output pc_state,
                  output now_ms, input ready);
  modport sink   (input valid, input func, input effect, input pc_state,
                  input now_ms, output ready);
endinterface : ptec_in_if

interface ptec_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] active_effect;
  logic [2:0] finished_effect;

  modport source (output valid, output active_effect, output finished_effect,
                  input ready);
  modport sink   (input valid, input active_effect, input finished_effect,
                  output ready);
endinterface : ptec_out_if

`default_nettype wire

[hw/rtl/priority_timed_effect_controller.sv]
// Priority timed effect controller, top level.
// An event passes the input register, then the result register, before its result transfer;
// a result that out_ch does not take holds the result register and stalls the input stage.
// Throughput: one event per cycle while out_ch takes results; the effect state is computed
// from the input register and registered, so back-to-back events see each other's effects.
// Reset (rst_n low, synchronous): no effect active or finished, start time and all
// durations zero, both pipeline stages empty. Depends on ptec_pkg and ptec_if.
`default_nettype none

module priority_timed_effect_controller (
  input  wire                         clk,
  input  wire                         rst_n,
  ptec_in_if.sink                     in_ch,
  ptec_out_if.source                  out_ch,
  input  wire                         cfg_we,
  input  wire [1:0]                   cfg_idx,
  input  wire [ptec_pkg::TimeW-1:0]   cfg_wdata
);
  import ptec_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration: effect durations in ms
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0] startup_dur_r;
  logic [TimeW-1:0] shutdown_dur_r;
  logic [TimeW-1:0] reset_dur_r;

  // ---------------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  logic [2:0]       s1_func_r;
  logic [2:0]       s1_effect_r;
  logic [1:0]       s1_ps_r;
  logic [TimeW-1:0] s1_now_r;

  // ---------------------------------------------------------------------------
  // Effect state
  // ---------------------------------------------------------------------------
  logic [2:0]       cur_fx_r, cur_fx_nxt;
  logic [2:0]       done_fx_r, done_fx_nxt;
  logic [TimeW-1:0] start_time_r, start_time_nxt;

  // Result register stage
  logic             out_valid_r;
  logic [2:0]       out_active_r;
  logic [2:0]       out_finished_r;

  // Handshake: the result register frees up when empty or being taken this cycle.
  logic out_free;
  logic s1_fire;
  logic in_xfer;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.active_effect   = out_active_r;
  assign out_ch.finished_effect = out_finished_r;

  // ---------------------------------------------------------------------------
  // Event evaluation
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] cur_dur;
  logic             cur_suits;
  logic             arm_ok;
  logic             is_arm;

  // wrapped elapsed time since the active effect started
  assign elapsed = s1_now_r - start_time_r;

  always_comb begin
    unique case (cur_fx_r)
      FX_STARTUP:  cur_dur = startup_dur_r;
      FX_RESET:    cur_dur = reset_dur_r;
      FX_SHUTDOWN: cur_dur = shutdown_dur_r;
      default:     cur_dur = '0;
    endcase
  end

  // power state compatibility for reconcile
  always_comb begin
    unique case (cur_fx_r)
      FX_NONE:     cur_suits = 1'b1;
      FX_STARTUP:  cur_suits = (s1_ps_r == PS_STARTING);
      FX_RESET:    cur_suits = (s1_ps_r == PS_RUNNING);
      FX_SHUTDOWN: cur_suits = (s1_ps_r == PS_SHUTTING);
      FX_FORCED:   cur_suits = (s1_ps_r == PS_RUNNING) || (s1_ps_r == PS_SHUTTING);
      default:     cur_suits = 1'b0;
    endcase
  end

  // Request skips the effect already active; restart re-arms it. Both skip
  // lower-priority effects, but a FX_NONE event is not gated and clears the state.
  assign is_arm = (s1_func_r == OP_REQUEST) || (s1_func_r == OP_RESTART);
  assign arm_ok = (s1_effect_r >= cur_fx_r) &&
                  !((s1_func_r == OP_REQUEST) && (s1_effect_r == cur_fx_r));

  always_comb begin
    cur_fx_nxt     = cur_fx_r;
    done_fx_nxt    = done_fx_r;
    start_time_nxt = start_time_r;
    if (s1_fire) begin
      priority if (is_arm) begin
        // unknown effect codes are ignored
        if (s1_effect_r == FX_NONE) begin
          cur_fx_nxt  = FX_NONE;
          done_fx_nxt = FX_NONE;
        end else if (s1_effect_r <= FX_FORCED && arm_ok) begin
          cur_fx_nxt     = s1_effect_r;
          done_fx_nxt    = FX_NONE;
          start_time_nxt = s1_now_r;
        end
      end else if (s1_func_r == OP_CANCEL) begin
        if (s1_effect_r == cur_fx_r) begin
          cur_fx_nxt  = FX_NONE;
          done_fx_nxt = FX_NONE;
        end
      end else if (s1_func_r == OP_RECONCILE) begin
        if (!cur_suits) begin
          cur_fx_nxt  = FX_NONE;
          done_fx_nxt = FX_NONE;
        end
      end else if (s1_func_r == OP_TICK) begin
        // forced shutdown never times out
        if (cur_fx_r != FX_NONE && cur_fx_r != FX_FORCED && elapsed >= cur_dur) begin
          cur_fx_nxt  = FX_NONE;
          done_fx_nxt = cur_fx_r;
        end
      end else if (s1_func_r == OP_CONSUME) begin
        done_fx_nxt = FX_NONE;
      end else begin
        // unknown operation: state holds
        cur_fx_nxt = cur_fx_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_dur_r  <= '0;
      shutdown_dur_r <= '0;
      reset_dur_r    <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      cur_fx_r       <= FX_NONE;
      done_fx_r      <= FX_NONE;
      start_time_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_STARTUP_DUR:  startup_dur_r  <= cfg_wdata;
          REG_SHUTDOWN_DUR: shutdown_dur_r <= cfg_wdata;
          REG_RESET_DUR:    reset_dur_r    <= cfg_wdata;
          default:          ;
        endcase
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      cur_fx_r     <= cur_fx_nxt;
      done_fx_r    <= done_fx_nxt;
      start_time_r <= start_time_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r   <= in_ch.func;
      s1_effect_r <= in_ch.effect;
      s1_ps_r     <= in_ch.pc_state;
      s1_now_r    <= in_ch.now_ms;
    end
    if (s1_fire) begin
      // finished effect is reported before consume clears it
      out_active_r   <= cur_fx_nxt;
      out_finished_r <= (s1_func_r == OP_CONSUME) ? done_fx_r : done_fx_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a finished effect only exists while nothing is active
  a_done_implies_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fx_r != FX_NONE) |-> (cur_fx_r == FX_NONE))
    else $error("finished effect held while an effect is active");

  // forced shutdown never retires
  a_forced_never_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_fx_r != FX_FORCED)
    else $error("forced shutdown reported as finished");

  // active effect stays a legal code
  a_cur_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cur_fx_r <= FX_FORCED)
    else $error("active effect code out of range");

  // a stalled input stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("input stage lost an item under stall");

  // state only moves when an event is evaluated
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> ($stable(cur_fx_r) && $stable(done_fx_r) && $stable(start_time_r)))
    else $error("effect state changed without an event");

endmodule : priority_timed_effect_controller

`default_nettype wire
